// ----- src/ktoi_pkg.sv -----
// ktoi_pkg: shared types and constants for the profile table key-to-index unit
// depends on nothing; imported by every module of the block
package ktoi_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int LIMIT_W    = 20;
    localparam int STEP_W     = 17;
    localparam int DIM_W      = 17;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int IDX_W      = PROD_W + 1;
    localparam int OUT_IDX_W  = 16;

    typedef enum logic [1:0] {
        KIND_TOKEN   = 2'd0,
        KIND_BATCH   = 2'd1,
        KIND_DECODE  = 2'd2,
        KIND_PREFILL = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND        = 3'd0,
        REG_TOKEN_LIMIT = 3'd1,
        REG_BATCH_LIMIT = 3'd2,
        REG_CACHE_STEP  = 3'd3,
        REG_CHUNK_STEP  = 3'd4,
        REG_TABLE_ROWS  = 3'd5,
        REG_TABLE_COLS  = 3'd6,
        REG_ENTRY_COUNT = 3'd7
    } cfg_reg_t;

    localparam logic [LIMIT_W-1:0] TOKEN_LIMIT_RST = 20'd4096;
    localparam logic [LIMIT_W-1:0] BATCH_LIMIT_RST = 20'd128;
    localparam logic [STEP_W-1:0]  STEP_RST        = 17'd1;

    // key facts worked out at the front and carried along the divider chain
    typedef struct packed {
        logic b_ok;      // b within token limit
        logic a_lt_pg;   // a below one chunk step
        logic a_gt_max;  // a above the largest chunk
        logic a_in01;    // a within [1, limit] for the 1-D and decode kinds
    } side_t;

endpackage

// ----- src/profile_table_key_to_index.sv -----
// profile_table_key_to_index: top level, configuration registers and divider chain
// depends on ktoi_pkg, ktoi_front, ktoi_cell, ktoi_back
//
//  channel   ports                                   timing
//  request   start, busy, key_a, key_b               taken when start && !busy
//  result    done, entry_index, index_valid, ...     one cycle, done strobe
//  config    cfg_write, cfg_index, cfg_data          written when cfg_write
//
// one request per cycle; results go through front, cells, s1, s2 and output registers
// the divider chain holds one cell per quotient bit of the key
// busy stays low; the pipeline never stalls and results cannot be held off
// reset clears the valid bits of every stage and loads the register defaults
module profile_table_key_to_index
    import ktoi_pkg::*;
#(
    parameter int KEY_BITS      = 20,
    parameter int TABLE_ENTRIES = 65536
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [KEY_BITS-1:0]   key_a,
    input  logic [KEY_BITS-1:0]   key_b,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [OUT_IDX_W-1:0]  entry_index,
    output logic                  index_valid,
    output logic                  key_clamped
);

    kind_t              kind_reg;
    logic [LIMIT_W-1:0] token_limit_reg;
    logic [LIMIT_W-1:0] batch_limit_reg;
    logic [STEP_W-1:0]  cache_step_reg;
    logic [STEP_W-1:0]  chunk_step_reg;
    logic [DIM_W-1:0]   table_rows_reg;
    logic [DIM_W-1:0]   table_cols_reg;
    logic [DIM_W-1:0]   entry_count_reg;

    logic [STEP_W-1:0]  cache_div;
    logic [STEP_W-1:0]  chunk_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= KIND_TOKEN;
            token_limit_reg <= TOKEN_LIMIT_RST;
            batch_limit_reg <= BATCH_LIMIT_RST;
            cache_step_reg  <= STEP_RST;
            chunk_step_reg  <= STEP_RST;
            table_rows_reg  <= '0;
            table_cols_reg  <= '0;
            entry_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KIND:        kind_reg        <= kind_t'(cfg_data[1:0]);
                REG_TOKEN_LIMIT: token_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_BATCH_LIMIT: batch_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_CACHE_STEP:  cache_step_reg  <= cfg_data[STEP_W-1:0];
                REG_CHUNK_STEP:  chunk_step_reg  <= cfg_data[STEP_W-1:0];
                REG_TABLE_ROWS:  table_rows_reg  <= cfg_data[DIM_W-1:0];
                REG_TABLE_COLS:  table_cols_reg  <= cfg_data[DIM_W-1:0];
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[DIM_W-1:0];
                default:         kind_reg        <= kind_reg;
            endcase
        end
    end

    // a zero step acts as one
    assign cache_div = (cache_step_reg == '0) ? STEP_W'(1) : cache_step_reg;
    assign chunk_div = (chunk_step_reg == '0) ? STEP_W'(1) : chunk_step_reg;
    assign busy = 1'b0;

    logic                vld_c   [KEY_BITS+1];
    side_t               side_c  [KEY_BITS+1];
    logic [KEY_BITS-1:0] afix_c  [KEY_BITS+1];
    logic [KEY_BITS-1:0] num_a_c [KEY_BITS+1];
    logic [KEY_BITS-1:0] num_b_c [KEY_BITS+1];
    logic [STEP_W-1:0]   rem_a_c [KEY_BITS+1];
    logic [STEP_W-1:0]   rem_b_c [KEY_BITS+1];

    ktoi_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (start && !busy),
        .key_a       (key_a),
        .key_b       (key_b),
        .kind        (kind_reg),
        .token_limit (token_limit_reg),
        .batch_limit (batch_limit_reg),
        .chunk_div   (chunk_div),
        .table_cols  (table_cols_reg),
        .vld_reg     (vld_c[0]),
        .side_reg    (side_c[0]),
        .a_fix_reg   (afix_c[0]),
        .a_reg       (num_a_c[0]),
        .bc_reg      (num_b_c[0])
    );

    assign rem_a_c[0] = '0;
    assign rem_b_c[0] = '0;

    for (genvar i = 0; i < KEY_BITS; i++)
    begin : g_cell
        ktoi_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .chunk_div (chunk_div),
            .cache_div (cache_div),
            .vld_in    (vld_c[i]),
            .side_in   (side_c[i]),
            .a_fix_in  (afix_c[i]),
            .num_a_in  (num_a_c[i]),
            .num_b_in  (num_b_c[i]),
            .rem_a_in  (rem_a_c[i]),
            .rem_b_in  (rem_b_c[i]),
            .vld_reg   (vld_c[i+1]),
            .side_reg  (side_c[i+1]),
            .a_fix_reg (afix_c[i+1]),
            .num_a_reg (num_a_c[i+1]),
            .num_b_reg (num_b_c[i+1]),
            .rem_a_reg (rem_a_c[i+1]),
            .rem_b_reg (rem_b_c[i+1])
        );
    end

    ktoi_back #(
        .KEY_BITS      (KEY_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .kind            (kind_reg),
        .table_rows      (table_rows_reg),
        .table_cols      (table_cols_reg),
        .entry_count     (entry_count_reg),
        .vld_in          (vld_c[KEY_BITS]),
        .side_in         (side_c[KEY_BITS]),
        .a_fix           (afix_c[KEY_BITS]),
        .quo_a           (num_a_c[KEY_BITS]),
        .quo_b           (num_b_c[KEY_BITS]),
        .rem_a           (rem_a_c[KEY_BITS]),
        .rem_b           (rem_b_c[KEY_BITS]),
        .done_reg        (done),
        .entry_index_reg (entry_index),
        .index_valid_reg (index_valid),
        .key_clamped_reg (key_clamped)
    );

endmodule

// ----- src/ktoi_front.sv -----
// ktoi_front: input register stage, limit clamps and range flags
// depends on ktoi_pkg
module ktoi_front
    import ktoi_pkg::*;
#(
    parameter int KEY_BITS = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [KEY_BITS-1:0] key_a,
    input  logic [KEY_BITS-1:0] key_b,
    input  kind_t               kind,
    input  logic [LIMIT_W-1:0]  token_limit,
    input  logic [LIMIT_W-1:0]  batch_limit,
    input  logic [STEP_W-1:0]   chunk_div,
    input  logic [DIM_W-1:0]    table_cols,
    output logic                vld_reg,
    output side_t               side_reg,
    output logic [KEY_BITS-1:0] a_fix_reg,
    output logic [KEY_BITS-1:0] a_reg,
    output logic [KEY_BITS-1:0] bc_reg
);

    localparam int CW = (KEY_BITS > STEP_W) ? KEY_BITS : STEP_W;

    logic [KEY_BITS-1:0] tlim;
    logic [KEY_BITS-1:0] lim;
    logic [KEY_BITS-1:0] a_hi;
    logic [KEY_BITS-1:0] a_fix_next;
    logic [KEY_BITS-1:0] bc_next;
    logic [DIM_W-1:0]    cols1;
    logic [PROD_W-1:0]   chunk_top;
    side_t               side_next;

    always_comb
    begin
        tlim = KEY_BITS'(token_limit);
        lim  = (kind == KIND_TOKEN) ? tlim : KEY_BITS'(batch_limit);
        // clamp to [1, lim]; a zero limit still ends at one
        a_hi = (key_a > lim) ? lim : key_a;
        a_fix_next = (a_hi == '0) ? KEY_BITS'(1) : a_hi;
        bc_next = (key_b > tlim) ? tlim : key_b;
        cols1 = (table_cols == '0) ? DIM_W'(1) : table_cols;
        chunk_top = PROD_W'(chunk_div) * PROD_W'(cols1);
        side_next.b_ok     = (key_b <= tlim);
        side_next.a_lt_pg  = (CW'(key_a) < CW'(chunk_div));
        side_next.a_gt_max = (PROD_W'(key_a) > chunk_top);
        side_next.a_in01   = (key_a != '0) && (key_a <= lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg  <= side_next;
        a_fix_reg <= a_fix_next;
        a_reg     <= key_a;
        bc_reg    <= bc_next;
    end

endmodule

// ----- src/ktoi_cell.sv -----
// ktoi_cell: one quotient bit of the two restoring dividers, plus the key facts
// depends on ktoi_pkg
module ktoi_cell
    import ktoi_pkg::*;
#(
    parameter int KEY_BITS = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [STEP_W-1:0]   chunk_div,
    input  logic [STEP_W-1:0]   cache_div,
    input  logic                vld_in,
    input  side_t               side_in,
    input  logic [KEY_BITS-1:0] a_fix_in,
    input  logic [KEY_BITS-1:0] num_a_in,
    input  logic [KEY_BITS-1:0] num_b_in,
    input  logic [STEP_W-1:0]   rem_a_in,
    input  logic [STEP_W-1:0]   rem_b_in,
    output logic                vld_reg,
    output side_t               side_reg,
    output logic [KEY_BITS-1:0] a_fix_reg,
    output logic [KEY_BITS-1:0] num_a_reg,
    output logic [KEY_BITS-1:0] num_b_reg,
    output logic [STEP_W-1:0]   rem_a_reg,
    output logic [STEP_W-1:0]   rem_b_reg
);

    logic [STEP_W:0]     sh_a;
    logic [STEP_W:0]     sh_b;
    logic                ge_a;
    logic                ge_b;
    logic [STEP_W-1:0]   rem_a_next;
    logic [STEP_W-1:0]   rem_b_next;
    logic [KEY_BITS-1:0] num_a_next;
    logic [KEY_BITS-1:0] num_b_next;

    // numerator bits leave at the top, quotient bits enter at the bottom
    always_comb
    begin
        sh_a = {rem_a_in, num_a_in[KEY_BITS-1]};
        sh_b = {rem_b_in, num_b_in[KEY_BITS-1]};
        ge_a = (sh_a >= {1'b0, chunk_div});
        ge_b = (sh_b >= {1'b0, cache_div});
        rem_a_next = ge_a ? STEP_W'(sh_a - {1'b0, chunk_div}) : sh_a[STEP_W-1:0];
        rem_b_next = ge_b ? STEP_W'(sh_b - {1'b0, cache_div}) : sh_b[STEP_W-1:0];
        num_a_next = {num_a_in[KEY_BITS-2:0], ge_a};
        num_b_next = {num_b_in[KEY_BITS-2:0], ge_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg  <= side_in;
        a_fix_reg <= a_fix_in;
        num_a_reg <= num_a_next;
        num_b_reg <= num_b_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
    end

endmodule

// ----- src/ktoi_back.sv -----
// ktoi_back: row/column selection, flat index multiply-add and range checks
// depends on ktoi_pkg
module ktoi_back
    import ktoi_pkg::*;
#(
    parameter int KEY_BITS      = 20,
    parameter int TABLE_ENTRIES = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kind_t                kind,
    input  logic [DIM_W-1:0]     table_rows,
    input  logic [DIM_W-1:0]     table_cols,
    input  logic [DIM_W-1:0]     entry_count,
    input  logic                 vld_in,
    input  side_t                side_in,
    input  logic [KEY_BITS-1:0]  a_fix,
    input  logic [KEY_BITS-1:0]  quo_a,
    input  logic [KEY_BITS-1:0]  quo_b,
    input  logic [STEP_W-1:0]    rem_a,
    input  logic [STEP_W-1:0]    rem_b,
    output logic                 done_reg,
    output logic [OUT_IDX_W-1:0] entry_index_reg,
    output logic                 index_valid_reg,
    output logic                 key_clamped_reg
);

    localparam int CW = (KEY_BITS > STEP_W) ? KEY_BITS : STEP_W;
    localparam logic [IDX_W-1:0] ENT_LIMIT = IDX_W'(TABLE_ENTRIES);

    logic              exact;
    logic [CW-1:0]     q_sel;
    logic [CW-1:0]     r_w;
    logic [CW-1:0]     c_w;
    logic [DIM_W-1:0]  m_w;
    logic [DIM_W-1:0]  cols1;
    logic              ok;
    logic              inrange;

    logic              s1_vld_reg;
    logic              s1_in_reg;
    logic              s1_exact_reg;
    logic [DIM_W-1:0]  s1_r_reg;
    logic [DIM_W-1:0]  s1_c_reg;
    logic [DIM_W-1:0]  s1_m_reg;

    logic              s2_vld_reg;
    logic              s2_in_reg;
    logic              s2_exact_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [DIM_W-1:0]  s2_c_reg;

    logic [IDX_W-1:0]  idx;
    logic              valid;

    always_comb
    begin
        cols1 = (table_cols == '0) ? DIM_W'(1) : table_cols;
        case (kind)
            KIND_TOKEN, KIND_BATCH: exact = side_in.a_in01;
            KIND_DECODE:  exact = side_in.a_in01 && side_in.b_ok && (rem_b == '0);
            KIND_PREFILL: exact = side_in.b_ok && (rem_b == '0) && !side_in.a_lt_pg
                                  && (rem_a == '0);
            default:      exact = 1'b0;
        endcase
        // chunk quotient after clamping to [step, step * cols] and flooring
        if (exact || (!side_in.a_lt_pg && !side_in.a_gt_max))
        begin
            q_sel = CW'(quo_a);
        end
        else if (side_in.a_lt_pg)
        begin
            q_sel = CW'(1);
        end
        else
        begin
            q_sel = CW'(cols1);
        end
        ok  = 1'b1;
        r_w = CW'(a_fix) - CW'(1);
        c_w = '0;
        m_w = DIM_W'(1);
        case (kind)
            KIND_DECODE:
            begin
                c_w = CW'(quo_b);
                m_w = table_cols;
            end
            KIND_PREFILL:
            begin
                ok  = (q_sel != '0);
                r_w = CW'(quo_b);
                c_w = q_sel - CW'(1);
                m_w = table_cols;
            end
            default:
            begin
                c_w = '0;
            end
        endcase
        inrange = ok && (r_w < CW'(table_rows)) && (c_w < CW'(m_w));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= vld_in;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    always_comb
    begin
        idx   = IDX_W'(s2_prod_reg) + IDX_W'(s2_c_reg);
        valid = s2_in_reg && (idx < IDX_W'(entry_count)) && (idx < ENT_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        s1_in_reg    <= inrange;
        s1_exact_reg <= exact;
        s1_r_reg     <= inrange ? r_w[DIM_W-1:0] : '0;
        s1_c_reg     <= inrange ? c_w[DIM_W-1:0] : '0;
        s1_m_reg     <= m_w;

        s2_in_reg    <= s1_in_reg;
        s2_exact_reg <= s1_exact_reg;
        s2_prod_reg  <= PROD_W'(s1_r_reg) * PROD_W'(s1_m_reg);
        s2_c_reg     <= s1_c_reg;

        entry_index_reg <= valid ? idx[OUT_IDX_W-1:0] : '0;
        index_valid_reg <= valid;
        key_clamped_reg <= !s2_exact_reg;
    end

endmodule

// ----- src/ktoi_check.sv -----
// ktoi_check: port-level checks for the key-to-index unit, bound to the top level
// depends on ktoi_pkg and profile_table_key_to_index
module ktoi_check
    import ktoi_pkg::*;
#(
    parameter int KEY_BITS = 20
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [OUT_IDX_W-1:0] entry_index,
    input logic                 index_valid
);

    localparam int LAT = KEY_BITS + 4;

    // every request yields its result after the fixed latency
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request without result");

    // no result without a matching earlier request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without request");

    // an invalid index reads as zero
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !index_valid) |-> (entry_index == '0))
        else $error("invalid index not zero");

endmodule

bind profile_table_key_to_index ktoi_check #(
    .KEY_BITS (KEY_BITS)
) u_ktoi_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .entry_index (entry_index),
    .index_valid (index_valid)
);

// ----- tb/tb_profile_table_key_to_index.sv -----
// tb_profile_table_key_to_index: self-checking bench for the cost table key-to-index unit
// depends on ktoi_pkg and profile_table_key_to_index; holds its own index predictor
`timescale 1ns / 100ps

module tb_profile_table_key_to_index;
    import ktoi_pkg::*;

    localparam int KEY_W    = 20;
    localparam int STORE_SZ = 65536;
    localparam int LATENCY  = KEY_W + 4;

    typedef struct {
        logic [OUT_IDX_W-1:0] idx;
        logic                 valid;
        logic                 clamped;
    } lookup_t;

    class cost_index_scoreboard;
        kind_t             kind;
        longint unsigned   tok_lim, bat_lim, cache_g, chunk_g, rows, cols, loaded;
        lookup_t           pending[$];
        int                errors;

        function new();
            kind    = KIND_TOKEN;
            tok_lim = 4096;
            bat_lim = 128;
            cache_g = 1;
            chunk_g = 1;
            rows    = 0;
            cols    = 0;
            loaded  = 0;
            errors  = 0;
        endfunction

        function void set_reg(cfg_reg_t r, longint unsigned v);
            case (r)
                REG_KIND:        kind    = kind_t'(v & 3);
                REG_TOKEN_LIMIT: tok_lim = v & 20'hFFFFF;
                REG_BATCH_LIMIT: bat_lim = v & 20'hFFFFF;
                REG_CACHE_STEP:  cache_g = v & 17'h1FFFF;
                REG_CHUNK_STEP:  chunk_g = v & 17'h1FFFF;
                REG_TABLE_ROWS:  rows    = v & 17'h1FFFF;
                REG_TABLE_COLS:  cols    = v & 17'h1FFFF;
                default:         loaded  = v & 17'h1FFFF;
            endcase
        endfunction

        function longint unsigned clip(longint unsigned v, longint unsigned lo,
                                       longint unsigned hi);
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            return v;
        endfunction

        function void note_request(logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb);
            longint unsigned a, b, kg, pg, top, row, col, q, idx;
            bit              exact, ok;
            lookup_t         e;
            a   = ka;
            b   = kb;
            kg  = (cache_g == 0) ? 1 : cache_g;
            pg  = (chunk_g == 0) ? 1 : chunk_g;
            ok  = 0;
            idx = 0;
            case (kind)
                KIND_TOKEN:  exact = a >= 1 && a <= tok_lim;
                KIND_BATCH:  exact = a >= 1 && a <= bat_lim;
                KIND_DECODE: exact = a >= 1 && a <= bat_lim && b <= tok_lim && b % kg == 0;
                default:     exact = b <= tok_lim && b % kg == 0 && a >= pg && a % pg == 0;
            endcase
            if (!exact) begin
                case (kind)
                    KIND_TOKEN: a = clip(a, 1, tok_lim);
                    KIND_BATCH: a = clip(a, 1, bat_lim);
                    KIND_DECODE:
                    begin
                        a = clip(a, 1, bat_lim);
                        if (b > tok_lim) b = tok_lim;
                        b = (b / kg) * kg;
                    end
                    default:
                    begin
                        top = pg * cols;
                        if (top < pg) top = pg;
                        if (b > tok_lim) b = tok_lim;
                        b = (b / kg) * kg;
                        a = clip(a, pg, top);
                        a = (a / pg) * pg;
                    end
                endcase
            end
            if (kind == KIND_TOKEN || kind == KIND_BATCH) begin
                if (a >= 1 && a <= rows) begin
                    idx = a - 1;
                    ok  = 1;
                end
            end else begin
                if (kind == KIND_DECODE) begin
                    row = a - 1;
                    col = b / kg;
                    q   = a;
                end else begin
                    q   = a / pg;
                    row = b / kg;
                    col = q - 1;
                end
                if (q >= 1 && row < rows && col < cols) begin
                    idx = row * cols + col;
                    ok  = 1;
                end
            end
            ok        = ok && idx < loaded && idx < STORE_SZ;
            e.idx     = ok ? idx[OUT_IDX_W-1:0] : '0;
            e.valid   = ok;
            e.clamped = !exact;
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(logic [OUT_IDX_W-1:0] idx, logic valid, logic clamped);
            lookup_t e;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: entry_index %0d", idx);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx) begin
                $error("entry_index expected %0d actual %0d", e.idx, idx);
                errors++;
            end
            if (valid !== e.valid) begin
                $error("index_valid expected %0d actual %0d", e.valid, valid);
                errors++;
            end
            if (clamped !== e.clamped) begin
                $error("key_clamped expected %0d actual %0d", e.clamped, clamped);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [KEY_W-1:0]      key_a;
    logic [KEY_W-1:0]      key_b;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done;
    logic [OUT_IDX_W-1:0]  entry_index;
    logic                  index_valid;
    logic                  key_clamped;

    cost_index_scoreboard lookups = new();

    profile_table_key_to_index dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .key_a       (key_a),
        .key_b       (key_b),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .entry_index (entry_index),
        .index_valid (index_valid),
        .key_clamped (key_clamped)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            lookups.check_result(entry_index, index_valid, key_clamped);
    end

    task automatic write_reg(cfg_reg_t r, int unsigned v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v[CFG_DATA_W-1:0];
        lookups.set_reg(r, v);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_all(int unsigned kind, int unsigned tl, int unsigned bl,
                             int unsigned cs, int unsigned ps, int unsigned nr,
                             int unsigned nc, int unsigned cnt);
        write_reg(REG_KIND, kind);
        write_reg(REG_TOKEN_LIMIT, tl);
        write_reg(REG_BATCH_LIMIT, bl);
        write_reg(REG_CACHE_STEP, cs);
        write_reg(REG_CHUNK_STEP, ps);
        write_reg(REG_TABLE_ROWS, nr);
        write_reg(REG_TABLE_COLS, nc);
        write_reg(REG_ENTRY_COUNT, cnt);
    endtask

    task automatic send_request(int unsigned a, int unsigned b, int unsigned gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        key_a <= a[KEY_W-1:0];
        key_b <= b[KEY_W-1:0];
        do
            @(posedge clk);
        while (busy);
        lookups.note_request(a[KEY_W-1:0], b[KEY_W-1:0]);
    endtask

    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        wait (lookups.pending.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // mostly keys near the grid of the current table, some raw noise
    task automatic random_requests(int n, bit bursty);
        int unsigned a, b, kg, pg, gap;
        kg = (lookups.cache_g == 0) ? 1 : 32'(lookups.cache_g);
        pg = (lookups.chunk_g == 0) ? 1 : 32'(lookups.chunk_g);
        for (int i = 0; i < n; i++) begin
            gap = bursty ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 4) == 0) begin
                a = $urandom();
                b = $urandom();
            end else begin
                case (lookups.kind)
                    KIND_TOKEN: a = $urandom_range(0, lookups.tok_lim + 2);
                    KIND_BATCH: a = $urandom_range(0, lookups.bat_lim + 2);
                    KIND_DECODE: a = $urandom_range(0, lookups.bat_lim + 2);
                    default: a = pg * $urandom_range(0, lookups.cols + 1);
                endcase
                if (lookups.kind == KIND_DECODE)
                    b = kg * $urandom_range(0, lookups.cols + 1);
                else
                    b = kg * $urandom_range(0, lookups.rows + 1);
                if ($urandom_range(0, 5) == 0) a = a + $urandom_range(1, 3);
                if ($urandom_range(0, 5) == 0) b = b + $urandom_range(1, 3);
            end
            send_request(a, b, gap);
        end
    endtask

    initial
    begin
        int unsigned nr, nc, cs, ps, cnt;
        rst_n     = 1'b0;
        start     = 1'b0;
        key_a     = '0;
        key_b     = '0;
        cfg_write = 1'b0;
        cfg_index = REG_KIND;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: empty table, every index invalid
        send_request(0, 0, 0);
        send_request(5000, 1, 0);
        send_request(20'hFFFFF, 20'hFFFFF, 1);
        drain();

        write_all(KIND_TOKEN, 32, 8, 4, 2, 8, 8, 60);
        for (int k = 0; k < 4; k++) begin
            if (k > 0)
                write_reg(REG_KIND, k);
            send_request(0, 0, 0);
            send_request(1, 4, 0);
            send_request(2, 3, 0);
            send_request(8, 28, 0);
            send_request(20'hFFFFF, 20'hFFFFF, 2);
            drain();
        end

        // large and zero values of every register
        write_all(KIND_PREFILL, 20'hFFFFF, 20'hFFFFF, 65536, 65536, 65536, 65536, 65536);
        random_requests(60, 0);
        drain();
        write_all(KIND_DECODE, 0, 0, 0, 0, 0, 0, 0);
        random_requests(40, 1);
        drain();
        write_all(KIND_DECODE, 20'hFFFFF, 20'hFFFFF, 1, 1, 65536, 65536, 65536);
        random_requests(60, 0);
        drain();

        for (int p = 0; p < 12; p++) begin
            nr  = ($urandom_range(0, 7) == 0) ? 65536 : $urandom_range(0, 16);
            nc  = ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(0, 16);
            cs  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65536) : $urandom_range(0, 8);
            ps  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65536) : $urandom_range(0, 8);
            cnt = ($urandom_range(0, 3) == 0) ? 65536
                  : $urandom_range(0, (nr * nc > 65536) ? 65536 : nr * nc + 4);
            write_all($urandom_range(0, 3),
                      ($urandom_range(0, 5) == 0) ? $urandom() & 20'hFFFFF
                          : (cs + 1) * ($urandom_range(0, nr + 2) + 1),
                      ($urandom_range(0, 5) == 0) ? $urandom() & 20'hFFFFF
                          : $urandom_range(0, nr + 2),
                      cs, ps, nr, nc, cnt);
            random_requests(150, p % 4 == 3);
            drain();
        end

        if (lookups.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
